FILE: src/mesi_pkg.sv
// Shared types, constants and helpers for the MESI set-associative cache controller.
package mesi_pkg;

  localparam int NUM_SETS   = 16;
  localparam int NUM_WAYS   = 4;
  localparam int LINE_BYTES = 8;
  localparam int OB = (LINE_BYTES <= 1) ? 1 : $clog2(LINE_BYTES);
  localparam int OBA = (LINE_BYTES <= 1) ? 0 : $clog2(LINE_BYTES);
  localparam int IBA = (NUM_SETS <= 1) ? 0 : $clog2(NUM_SETS);
  localparam int TAG_W = 32 - OBA - IBA;
  localparam int WB = (NUM_WAYS <= 1) ? 1 : $clog2(NUM_WAYS);
  localparam int LINE_W = 8 * LINE_BYTES;
  localparam int NLINES = NUM_SETS * NUM_WAYS;
  localparam int SI_W = (NUM_SETS <= 1) ? 1 : $clog2(NUM_SETS);

  // Startup wait count after reset
  localparam logic [7:0] WAIT_RESET = 8'd5;

  typedef enum logic [1:0] {
    ST_I = 2'd0, ST_S = 2'd1, ST_E = 2'd2, ST_M = 2'd3
  } mesi_t;

  typedef enum logic [1:0] {
    CMD_CPU = 2'd0, CMD_SET = 2'd1, CMD_GET = 2'd2, CMD_NOP = 2'd3
  } cmd_t;

  localparam logic [2:0] STAT_DONE = 3'd0;
  localparam logic [2:0] STAT_WAIT = 3'd1;
  localparam logic [2:0] STAT_FILL = 3'd2;
  localparam logic [2:0] STAT_MISS_BUSY = 3'd3;
  localparam logic [2:0] STAT_WB_DONE = 3'd4;
  localparam logic [2:0] STAT_INV_BUSY = 3'd5;

  localparam logic [2:0] BREQ_NONE = 3'd0;
  localparam logic [2:0] BREQ_RD = 3'd1;
  localparam logic [2:0] BREQ_RFO = 3'd2;
  localparam logic [2:0] BREQ_INV = 3'd3;
  localparam logic [2:0] BREQ_WB = 3'd4;

  typedef enum logic [1:0] {
    CS_IDLE, CS_LOOK, CS_OUT
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture input item, read the line row of its set
    logic exec;      // evaluate and update state, register result
  } dp_cmd_t;

endpackage

FILE: src/mesi_datapath.sv
// Datapath: line stores, lookup, hit/miss handling and result register.
module mesi_datapath
  import mesi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [7:0]       cfg_data,
  input  logic             cfg_we,
  input  logic [1:0]       i_cmd,
  input  logic [31:0]      i_addr,
  input  logic [31:0]      i_wdata,
  input  logic             i_wr,
  input  logic [1:0]       i_size,
  input  logic [1:0]       i_nstate,
  input  logic             i_bus_ok,
  input  logic             i_shared,
  input  logic [63:0]      i_fill,
  output logic [161:0]     result
);

  // Line stores: one row per set holding all ways; data row is a memory
  logic [NUM_WAYS-1:0][LINE_W-1:0] data_mem [NUM_SETS];
  logic [NUM_WAYS-1:0][TAG_W-1:0]  tag_r    [NUM_SETS];
  logic [NUM_WAYS-1:0][1:0]        state_r  [NUM_SETS];
  logic [NUM_WAYS-1:0] mru_r [NUM_SETS];
  logic [7:0] wait_r;

  // Captured item
  logic [1:0]  cmd_q;
  logic [31:0] addr_q, wdata_q;
  logic        wr_q, ok_q, sh_q;
  logic [1:0]  size_q, ns_q;
  logic [63:0] fill_q;
  logic [NUM_WAYS-1:0][LINE_W-1:0] rd_row_r;

  logic [SI_W-1:0] set_i, set_q;
  logic [TAG_W-1:0] tag_q;
  logic [OB-1:0] off_q;

  always_comb begin
    set_i = SI_W'((NUM_SETS <= 1) ? 0 :
            ((i_addr >> OBA) & ((32'd1 << IBA) - 32'd1)) % NUM_SETS);
  end

  // Capture and read the data row of the set
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q <= i_cmd; addr_q <= i_addr; wdata_q <= i_wdata; wr_q <= i_wr;
      size_q <= i_size; ns_q <= i_nstate; ok_q <= i_bus_ok; sh_q <= i_shared;
      fill_q <= i_fill; set_q <= set_i;
      rd_row_r <= data_mem[set_i];
    end
  end

  always_comb begin
    tag_q = TAG_W'(addr_q >> (OBA + IBA));
    off_q = OB'(addr_q % LINE_BYTES);
  end

  // Lookup
  logic hit_f;
  logic [WB-1:0] hway;
  logic [WB-1:0] vway;
  logic all_mru;
  always_comb begin
    hit_f = 1'b0; hway = '0; vway = '0; all_mru = 1'b1;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (tag_r[set_q][w] == tag_q) begin
        hit_f = 1'b1; hway = WB'(w);
      end
      if (!mru_r[set_q][w]) begin
        vway = WB'(w); all_mru = 1'b0;
      end
    end
  end

  mesi_t hst, vst;
  logic [LINE_W-1:0] hline;
  always_comb begin
    hst = mesi_t'(state_r[set_q][hway]);
    vst = mesi_t'(state_r[set_q][vway]);
    hline = rd_row_r[hway];
  end

  // Byte load/store with wraparound
  logic [2:0] nbytes;
  logic [31:0] ld;
  logic [LINE_W-1:0] stline;
  always_comb begin
    unique case (size_q)
      2'd3: nbytes = 3'd4;
      2'd2: nbytes = 3'd2;
      2'd1: nbytes = 3'd1;
      default: nbytes = wr_q ? 3'd0 : 3'd1;
    endcase
    ld = '0;
    stline = hline;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < nbytes) begin
        ld[8*k +: 8] = hline[8*((int'(off_q) + k) % LINE_BYTES) +: 8];
        stline[8*((int'(off_q) + k) % LINE_BYTES) +: 8] = wdata_q[8*k +: 8];
      end
    end
  end

  // Evaluate the access
  logic succ; logic [2:0] stat, breq; logic [31:0] rdata, baddr;
  logic [24:0] vtag; logic [63:0] vline; logic [1:0] sst;
  logic do_touch, do_clear, do_data, do_fill, do_st;
  logic [WB-1:0] st_way; mesi_t st_v; logic [LINE_W-1:0] dnew;
  logic [NUM_WAYS-1:0] mnew;
  always_comb begin
    succ = 1'b0; stat = STAT_DONE; rdata = '0; breq = BREQ_NONE; baddr = '0;
    vtag = '0; vline = '0; sst = '0;
    do_touch = 1'b0; do_clear = 1'b0; do_data = 1'b0; do_fill = 1'b0; do_st = 1'b0;
    st_way = hway; st_v = ST_I; dnew = stline;
    unique case (cmd_q)
      CMD_SET: begin
        if (hit_f) begin do_st = 1'b1; st_v = mesi_t'(ns_q); end
      end
      CMD_GET: if (hit_f) sst = hst;
      CMD_CPU: begin
        if (wait_r != 8'd0) stat = STAT_WAIT;
        else if (hit_f && hst != ST_I) begin
          if (!wr_q) begin
            rdata = ld; do_touch = 1'b1; succ = 1'b1;
          end else begin
            if (hst == ST_S) begin breq = BREQ_INV; baddr = addr_q; end
            if (hst != ST_S || ok_q) begin
              do_st = 1'b1; st_v = ST_M; do_data = 1'b1; do_touch = 1'b1; succ = 1'b1;
            end else stat = STAT_INV_BUSY;
          end
        end else begin
          do_clear = all_mru;
          st_way = vway; baddr = addr_q;
          if (vst == ST_M) begin
            breq = BREQ_WB;
            vtag = 25'(tag_r[set_q][vway]);
            vline = 64'(rd_row_r[vway]);
            if (ok_q) begin do_st = 1'b1; st_v = ST_I; stat = STAT_WB_DONE; end
            else stat = STAT_MISS_BUSY;
          end else begin
            breq = wr_q ? BREQ_RFO : BREQ_RD;
            if (ok_q) begin
              do_fill = 1'b1; do_st = 1'b1; do_data = 1'b1; dnew = LINE_W'(fill_q);
              st_v = wr_q ? ST_M : (sh_q ? ST_S : ST_E);
              stat = STAT_FILL;
            end else stat = STAT_MISS_BUSY;
          end
        end
      end
      default: ;
    endcase
    mnew = mru_r[set_q];
    if (do_clear) mnew = '0;
    if (do_touch) begin
      mnew[hway] = 1'b1;
      if (&mnew) mnew = '0;
    end
    if (do_fill) mnew[vway] = 1'b0;
  end

  // Commit updates and register result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        tag_r[s] <= '0;
        state_r[s] <= {NUM_WAYS{ST_I}};
        mru_r[s] <= '0;
      end
      wait_r <= WAIT_RESET;
    end else if (cfg_we) begin
      wait_r <= cfg_data;
    end else if (cmd.exec) begin
      if (cmd_q == CMD_CPU && wait_r != 8'd0) wait_r <= wait_r - 8'd1;
      if (do_st) state_r[set_q][st_way] <= st_v;
      if (do_fill) tag_r[set_q][st_way] <= tag_q;
      mru_r[set_q] <= mnew;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_data) data_mem[set_q][st_way] <= dnew;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) result <= {sst, vline, vtag, baddr, breq, rdata, stat, succ};
  end

endmodule

FILE: src/mesi_ctrl.sv
// Controller: sequences capture, execute and result handshake.
module mesi_ctrl
  import mesi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CS_IDLE;
    else state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin cmd.load_in = 1'b1; state_nxt = CS_LOOK; end
      end
      CS_LOOK: begin cmd.exec = 1'b1; state_nxt = CS_OUT; end
      CS_OUT: begin
        out_tvalid = 1'b1;
        in_tready = out_tready;
        if (out_tready) begin
          if (in_tvalid) begin cmd.load_in = 1'b1; state_nxt = CS_LOOK; end
          else state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule

FILE: src/mesi_set_assoc_cache_controller_core.sv
// Top level of the MESI set-associative cache controller.
// The input transfer captures the item, CS_LOOK executes it and registers the result,
// and CS_OUT offers it; the next input is taken as the result transfers.
// Line data is a one-port memory with one row per set, read at capture, written at execute.
// Reset (synchronous, rst_n low) invalidates all lines, clears tags and MRU bits
// and loads the startup wait count with 5; no clearing pass is needed.
module mesi_set_assoc_cache_controller_core
  import mesi_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // address[31:0], write_data[63:32], is_write[64], size_code[66:65],
  // snoop_new_state[68:67], bus_success[69], bus_shared[70], fill_line[134:71]
  input  logic [135:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // success[0], status[3:1], read_data[35:4], bus request code[38:36],
  // bus_address[70:39], victim_tag[95:71], victim_line[159:96], snoop_state[161:160]
  output logic [167:0] out_tdata,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata
);

  dp_cmd_t cmd;
  logic [161:0] res;

  mesi_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd
  );

  mesi_datapath u_dp (
    .clk, .rst_n, .cmd,
    .cfg_data (cfg_wdata), .cfg_we (cfg_we),
    .i_cmd    (in_tuser),
    .i_addr   (in_tdata[31:0]),
    .i_wdata  (in_tdata[63:32]),
    .i_wr     (in_tdata[64]),
    .i_size   (in_tdata[66:65]),
    .i_nstate (in_tdata[68:67]),
    .i_bus_ok (in_tdata[69]),
    .i_shared (in_tdata[70]),
    .i_fill   (in_tdata[134:71]),
    .result   (res)
  );

  assign out_tdata = {6'd0, res};

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the MESI set-associative cache controller core.
module testbench;
  import mesi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        wr;
    logic [1:0]  size;
    mesi_t       nstate;
    logic        bus_ok;
    logic        shared;
    logic [63:0] fill;
  } access_t;

  typedef struct {
    logic             succ;
    logic [2:0]       status;
    logic [31:0]      rdata;
    logic [2:0]       breq;
    logic [31:0]      baddr;
    logic [24:0]      vtag;
    logic [63:0]      vline;
    logic [1:0]       sstate;
  } reply_t;

  localparam int CYCLE_LIMIT = 300000;
  localparam int STALL_CYCLES = 80;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [167:0] out_tdata;
  logic         cfg_we;
  logic [7:0]   cfg_wdata;

  // cache image kept by the predictor
  logic [LINE_W-1:0] cache_data [NLINES];
  logic [TAG_W-1:0]  cache_tag  [NLINES];
  mesi_t             cache_st   [NLINES];
  logic              cache_mru  [NLINES];
  logic              data_known [NLINES];
  logic [7:0]        wait_count;

  reply_t expected_q [$];
  int     fail_count;
  int     cycle_count;
  logic   no_idle;
  logic   stall_req;

  mesi_set_assoc_cache_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int find_line(logic [31:0] addr);
    int base;
    base = int'(addr[OBA +: IBA]) * NUM_WAYS;
    for (int w = 0; w < NUM_WAYS; w++)
      if (cache_tag[base + w] == addr[31:OBA+IBA]) return base + w;
    return -1;
  endfunction

  function automatic int byte_len(logic [1:0] size, logic wr);
    if (size == 2'd3) return 4;
    if (size == 2'd2) return 2;
    if (size == 2'd0 && wr) return 0;
    return 1;
  endfunction

  // mark a way most recently used, clear the set once every way is marked
  task automatic mark_used(int li);
    int  base;
    logic full;
    base = (li / NUM_WAYS) * NUM_WAYS;
    full = 1'b1;
    cache_mru[li] = 1'b1;
    for (int w = 0; w < NUM_WAYS; w++) full &= cache_mru[base + w];
    if (full)
      for (int w = 0; w < NUM_WAYS; w++) cache_mru[base + w] = 1'b0;
  endtask

  // advance the cache image by one transfer and return the reply it causes
  task automatic cache_predict(input access_t a, output reply_t r);
    int li, base, vw, off, n, pos;
    r = '{default: '0};
    li = find_line(a.addr);
    base = int'(a.addr[OBA +: IBA]) * NUM_WAYS;
    off = int'(a.addr[OBA-1:0]) % LINE_BYTES;
    case (a.cmd)
      CMD_SET: if (li >= 0) cache_st[li] = a.nstate;
      CMD_GET: if (li >= 0) r.sstate = cache_st[li];
      CMD_CPU: begin
        if (wait_count > 0) begin
          wait_count--;
          r.status = STAT_WAIT;
        end else if (li >= 0 && cache_st[li] != ST_I) begin
          n = byte_len(a.size, a.wr);
          if (!a.wr) begin
            for (int k = 0; k < n; k++) begin
              pos = (off + k) % LINE_BYTES;
              r.rdata[8*k +: 8] = cache_data[li][8*pos +: 8];
            end
            mark_used(li);
            r.succ = 1'b1;
          end else if (cache_st[li] == ST_S && !a.bus_ok) begin
            r.breq = BREQ_INV;
            r.baddr = a.addr;
            r.status = STAT_INV_BUSY;
          end else begin
            if (cache_st[li] == ST_S) begin
              r.breq = BREQ_INV;
              r.baddr = a.addr;
            end
            cache_st[li] = ST_M;
            for (int k = 0; k < n; k++) begin
              pos = (off + k) % LINE_BYTES;
              cache_data[li][8*pos +: 8] = a.wdata[8*k +: 8];
            end
            mark_used(li);
            r.succ = 1'b1;
          end
        end else begin
          vw = -1;
          for (int w = 0; w < NUM_WAYS; w++)
            if (vw < 0 && !cache_mru[base + w]) vw = w;
          if (vw < 0) begin
            for (int w = 0; w < NUM_WAYS; w++) cache_mru[base + w] = 1'b0;
            vw = 0;
          end
          li = base + vw;
          r.baddr = a.addr;
          if (cache_st[li] == ST_M) begin
            r.breq = BREQ_WB;
            r.vtag = cache_tag[li][24:0];
            r.vline = cache_data[li];
            if (a.bus_ok) cache_st[li] = ST_I;
            r.status = a.bus_ok ? STAT_WB_DONE : STAT_MISS_BUSY;
          end else begin
            r.breq = a.wr ? BREQ_RFO : BREQ_RD;
            if (a.bus_ok) begin
              cache_data[li] = a.fill[LINE_W-1:0];
              data_known[li] = 1'b1;
              cache_tag[li] = a.addr[31:OBA+IBA];
              cache_st[li] = a.wr ? ST_M : (a.shared ? ST_S : ST_E);
              cache_mru[li] = 1'b0;
              r.status = STAT_FILL;
            end else begin
              r.status = STAT_MISS_BUSY;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic access_t make_access(cmd_t cmd, logic [31:0] addr, logic [31:0] wdata,
                                         logic wr, logic [1:0] size, mesi_t ns,
                                         logic ok, logic sh, logic [63:0] fill);
    access_t a;
    a.cmd = cmd; a.addr = addr; a.wdata = wdata; a.wr = wr; a.size = size;
    a.nstate = ns; a.bus_ok = ok; a.shared = sh; a.fill = fill;
    return a;
  endfunction

  function automatic logic [31:0] line_addr(logic [24:0] tg, int set, int off);
    return {tg, 4'(set), 3'(off)};
  endfunction

  // send one access, never validating a line whose data was never filled
  task automatic send_access(input access_t a);
    reply_t r;
    int li;
    li = find_line(a.addr);
    if (a.cmd == CMD_SET && li >= 0 && !data_known[li]) a.nstate = ST_I;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = a.cmd;
    in_tdata = {1'b0, a.fill, a.shared, a.bus_ok, a.nstate, a.size, a.wr,
                a.wdata, a.addr};
    do @(posedge clk); while (!in_tready);
    cache_predict(a, r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write the startup wait count while the block is idle
  task automatic write_wait(input logic [7:0] v);
    drain();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    wait_count = v;
  endtask

  function automatic access_t random_access;
    access_t a;
    logic [24:0] tags [6] = '{25'd0, 25'd1, 25'd2, 25'd3, 25'h1FFFFFF, 25'h1555555};
    int p;
    p = $urandom_range(99);
    a.cmd = p < 78 ? CMD_CPU : p < 88 ? CMD_SET : p < 97 ? CMD_GET : CMD_NOP;
    if ($urandom_range(99) < 85)
      a.addr = line_addr(tags[$urandom_range(5)],
                         $urandom_range(99) < 70 ? $urandom_range(3) : $urandom_range(15),
                         $urandom_range(7));
    else
      a.addr = $urandom;
    a.wdata = $urandom;
    a.wr = 1'($urandom_range(1));
    a.size = 2'($urandom_range(3));
    a.nstate = mesi_t'($urandom_range(3));
    a.bus_ok = $urandom_range(99) < 75;
    a.shared = 1'($urandom_range(1));
    a.fill = {$urandom, $urandom};
    return a;
  endfunction

  task automatic test_directed;
    logic [31:0] a_addr, b_addr, c_addr, d_addr;
    a_addr = line_addr(25'd1, 2, 6);
    b_addr = line_addr(25'h1FFFFFF, 2, 0);
    c_addr = line_addr(25'd2, 5, 3);
    d_addr = line_addr(25'd3, 5, 7);
    // startup wait after reset
    for (int i = 0; i < 5; i++)
      send_access(make_access(CMD_CPU, a_addr, '1, i[0], 2'(i), ST_I, 1'b1, 1'b0, '0));
    send_access(make_access(CMD_GET, a_addr, '0, 1'b0, 2'd0, ST_I, 1'b0, 1'b0, '0));
    send_access(make_access(CMD_CPU, a_addr, '0, 1'b0, 2'd3, ST_I, 1'b0, 1'b1, '1));
    send_access(make_access(CMD_CPU, a_addr, '0, 1'b0, 2'd3, ST_I, 1'b1, 1'b1,
                            64'h8877665544332211));
    // load that wraps past the line end
    send_access(make_access(CMD_CPU, a_addr, '0, 1'b0, 2'd3, ST_I, 1'b0, 1'b0, '0));
    // store to a shared line: invalidate refused, then granted
    send_access(make_access(CMD_CPU, a_addr, 32'hCAFEF00D, 1'b1, 2'd3, ST_I, 1'b0, 1'b0, '0));
    send_access(make_access(CMD_CPU, a_addr, 32'hA5A5BEEF, 1'b1, 2'd2, ST_I, 1'b1, 1'b0, '0));
    send_access(make_access(CMD_CPU, a_addr, 32'hFFFFFFFF, 1'b1, 2'd0, ST_I, 1'b1, 1'b0, '0));
    send_access(make_access(CMD_CPU, a_addr, '0, 1'b0, 2'd1, ST_I, 1'b0, 1'b0, '0));
    send_access(make_access(CMD_GET, a_addr, '0, 1'b0, 2'd0, ST_I, 1'b0, 1'b0, '0));
    send_access(make_access(CMD_CPU, b_addr, '0, 1'b0, 2'd3, ST_I, 1'b1, 1'b0, '1));
    // modified victim: save refused, save done, then refill
    send_access(make_access(CMD_CPU, c_addr, 32'h12345678, 1'b1, 2'd3, ST_I, 1'b1, 1'b0,
                            64'h0123456789ABCDEF));
    send_access(make_access(CMD_CPU, d_addr, '0, 1'b0, 2'd3, ST_I, 1'b0, 1'b0, '0));
    send_access(make_access(CMD_CPU, d_addr, '0, 1'b0, 2'd3, ST_I, 1'b1, 1'b0, '0));
    send_access(make_access(CMD_CPU, d_addr, '0, 1'b0, 2'd3, ST_I, 1'b1, 1'b0, '1));
    send_access(make_access(CMD_SET, a_addr, '0, 1'b0, 2'd0, ST_I, 1'b0, 1'b0, '0));
    send_access(make_access(CMD_CPU, a_addr, '0, 1'b0, 2'd3, ST_I, 1'b1, 1'b1, '0));
    send_access(make_access(CMD_NOP, '1, '1, 1'b1, 2'd3, ST_M, 1'b1, 1'b1, '1));
    send_access(make_access(CMD_SET, b_addr, '0, 1'b0, 2'd0, ST_M, 1'b0, 1'b0, '0));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_access(random_access());
  endtask

  // hold the receiver off while the sender keeps offering
  task automatic test_backpressure(input int n);
    stall_req = 1'b1;
    test_random(n);
  endtask

  task automatic test_steady(input int n);
    no_idle = 1'b1;
    test_random(n);
    no_idle = 1'b0;
  endtask

  // receiver side
  initial begin
    logic stall_done;
    stall_done = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req && !stall_done) begin
        out_tready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end
      out_tready = no_idle || $urandom_range(99) >= 24;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[0] !== e.succ) begin
          $error("success exp %h got %h", e.succ, out_tdata[0]); fail_count++;
        end
        if (out_tdata[3:1] !== e.status) begin
          $error("status exp %h got %h", e.status, out_tdata[3:1]); fail_count++;
        end
        if (out_tdata[35:4] !== e.rdata) begin
          $error("read_data exp %h got %h", e.rdata, out_tdata[35:4]); fail_count++;
        end
        if (out_tdata[38:36] !== e.breq) begin
          $error("bus_req exp %h got %h", e.breq, out_tdata[38:36]); fail_count++;
        end
        if (out_tdata[70:39] !== e.baddr) begin
          $error("bus_address exp %h got %h", e.baddr, out_tdata[70:39]); fail_count++;
        end
        if (out_tdata[95:71] !== e.vtag) begin
          $error("victim_tag exp %h got %h", e.vtag, out_tdata[95:71]); fail_count++;
        end
        if (out_tdata[159:96] !== e.vline) begin
          $error("victim_line exp %h got %h", e.vline, out_tdata[159:96]); fail_count++;
        end
        if (out_tdata[161:160] !== e.sstate) begin
          $error("snoop_state exp %h got %h", e.sstate, out_tdata[161:160]); fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    stall_req = 1'b0;
    for (int i = 0; i < NLINES; i++) begin
      cache_data[i] = '0;
      cache_tag[i] = '0;
      cache_st[i] = ST_I;
      cache_mru[i] = 1'b0;
      data_known[i] = 1'b0;
    end
    wait_count = WAIT_RESET;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    write_wait(8'd255);
    test_random(300);
    write_wait(8'd0);
    test_backpressure(300);
    test_steady(250);
    write_wait(8'($urandom_range(1, 20)));
    test_random(480);
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
